// File: rtl/core/bst_pkg.sv
`timescale 1ns / 1ps
// bst_pkg: shared types, event and error codes and byte constants for the
// bencode stream tokenizer; no dependencies
package bst_pkg;

  // default sizing
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned LEN_BITS_DEF    = 32;

  // field widths
  localparam int unsigned ACC_W  = 63;
  localparam int unsigned SUM_W  = ACC_W + 4;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned NEST_W = 5;
  localparam int unsigned LENO_W = 32;

  localparam logic [NEST_W-1:0] MAX_NEST_RST = 5'd16;

  // event kinds
  localparam logic [KIND_W-1:0] EV_HDR   = 3'd0;
  localparam logic [KIND_W-1:0] EV_BYTE  = 3'd1;
  localparam logic [KIND_W-1:0] EV_INT   = 3'd2;
  localparam logic [KIND_W-1:0] EV_LIST  = 3'd3;
  localparam logic [KIND_W-1:0] EV_DICT  = 3'd4;
  localparam logic [KIND_W-1:0] EV_CLOSE = 3'd5;
  localparam logic [KIND_W-1:0] EV_ERR   = 3'd6;

  // error codes
  localparam logic [ERR_W-1:0] ERR_BAD_LEN  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_INT  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_KEY      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_TYPE = 3'd4;
  localparam logic [ERR_W-1:0] ERR_DEEP     = 3'd5;
  localparam logic [ERR_W-1:0] ERR_OVF      = 3'd6;

  // stream bytes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // one nesting level: container kind and dict key/value phase
  typedef struct packed {
    logic want_val;
    logic dict;
  } lvl_ent_t;

  // overflow status of the decimal accumulator
  typedef struct packed {
    logic len_ovf;
    logic int_ovf;
  } acc_stat_t;

endpackage

// File: rtl/core/bencode_stream_tokenizer.sv
`timescale 1ns / 1ps
// bencode_stream_tokenizer: top level, parse state machine and output register
// depends on bst_pkg, bst_stack_mem and bst_digit_acc

// Takes one bencoded byte per beat and emits at most one token event per byte:
// string header with its length, string body bytes, integer value, list or
// dict open, close, or an error; after an error the block drops all input
// until reset. Bytes are taken back to back, one per beat, while in_stall is low.
// The nesting stack lives in a memory with a registered read port; the top
// level is held in a register and the entry below it is kept prefetched, with
// write forwarding, so a close never waits on the memory port. No clearing
// pass is needed after reset. in_stall is high only while a result waits in
// the output register and out_stall holds it.
module bencode_stream_tokenizer #(
  parameter int unsigned STACK_DEPTH = bst_pkg::STACK_DEPTH_DEF,
  parameter int unsigned LEN_BITS    = bst_pkg::LEN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [bst_pkg::NEST_W-1:0] cfg_wr_data,
  // byte input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte,
  // event output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bst_pkg::KIND_W-1:0] out_event_kind,
  output logic [7:0]                 out_data_byte,
  output logic                       out_str_last,
  output logic [bst_pkg::LENO_W-1:0] out_str_length,
  output logic [bst_pkg::ACC_W-1:0]  out_int_value,
  output logic [bst_pkg::NEST_W-1:0] out_nest_depth,
  output logic                       out_is_key,
  output logic [bst_pkg::ERR_W-1:0]  out_error_code
);
  import bst_pkg::*;

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CMP_W = (LVL_W > NEST_W) ? LVL_W : NEST_W;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LEN,
    MODE_BODY,
    MODE_INT,
    MODE_HALT
  } mode_t;

  // state
  mode_t               mode_r,  mode_nxt;
  logic [ACC_W-1:0]    acc_r,   acc_nxt;
  logic                seen_r,  seen_nxt;
  logic [LEN_BITS-1:0] left_r,  left_nxt;
  logic [LVL_W-1:0]    lvl_r,   lvl_nxt;
  lvl_ent_t            top_r,   top_nxt;
  logic                key_r,   key_nxt;
  logic [NEST_W-1:0]   max_nest_r;

  // output register
  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [7:0]         data_r;
  logic               last_r;
  logic [LENO_W-1:0]  len_r;
  logic [ACC_W-1:0]   int_r;
  logic [NEST_W-1:0]  depth_r;
  logic               is_key_r;
  logic [ERR_W-1:0]   err_r;

  // result of this beat
  logic               res_fire;
  logic [KIND_W-1:0]  res_kind;
  logic [7:0]         res_data;
  logic               res_last;
  logic [LENO_W-1:0]  res_len;
  logic [ACC_W-1:0]   res_int;
  logic [LVL_W-1:0]   res_lvl;
  logic               res_key;
  logic [ERR_W-1:0]   res_err;
  logic [LVL_W+NEST_W-1:0] res_lvl_ext;

  // stack memory side
  logic               stk_wr_en;
  logic [AW-1:0]      stk_wr_addr;
  logic [AW-1:0]      stk_rd_addr;
  lvl_ent_t           below;
  logic [LVL_W-1:0]   lvl_m1;
  logic [LVL_W-1:0]   lvl_nxt_m2;

  // decode helpers
  logic               in_acc;
  logic               is_digit;
  logic [3:0]         digit;
  logic [ACC_W-1:0]   acc_sum;
  acc_stat_t          acc_stat;
  logic               key_pos;
  logic               too_deep;
  lvl_ent_t           top_done;
  lvl_ent_t           below_done;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign digit    = in_byte[3:0];

  // decimal accumulator step
  bst_digit_acc #(
    .LEN_BITS (LEN_BITS)
  ) u_acc (
    .acc   (acc_r),
    .digit (digit),
    .sum   (acc_sum),
    .stat  (acc_stat)
  );

  // stack memory holds every level below the registered top
  assign lvl_m1      = lvl_r - LVL_W'(1);
  assign lvl_nxt_m2  = lvl_nxt - LVL_W'(2);
  assign stk_wr_addr = lvl_m1[AW-1:0];
  assign stk_rd_addr = lvl_nxt_m2[AW-1:0];

  bst_stack_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (top_r),
    .rd_addr (stk_rd_addr),
    .rd_data (below)
  );

  // level status
  assign key_pos  = (lvl_r != '0) && top_r.dict && !top_r.want_val;
  assign too_deep = (lvl_r >= LVL_W'(STACK_DEPTH)) ||
                    (CMP_W'(lvl_r) >= CMP_W'(max_nest_r));

  // finishing an object flips a dict between key and value
  always_comb begin
    top_done   = top_r;
    below_done = below;
    if ((lvl_r != '0) && top_r.dict) begin
      top_done.want_val = ~top_r.want_val;
    end
    if (below.dict) begin
      below_done.want_val = ~below.want_val;
    end
  end

  // parse step
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    left_nxt  = left_r;
    lvl_nxt   = lvl_r;
    top_nxt   = top_r;
    key_nxt   = key_r;
    stk_wr_en = 1'b0;
    res_fire  = 1'b0;
    res_kind  = EV_HDR;
    res_data  = '0;
    res_last  = 1'b0;
    res_len   = '0;
    res_int   = '0;
    res_lvl   = lvl_r;
    res_key   = 1'b0;
    res_err   = ERR_BAD_LEN;
    if (in_acc) begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (in_byte == CH_E) begin
            if ((lvl_r == '0) || (top_r.dict && top_r.want_val)) begin
              res_fire = 1'b1;
              res_kind = EV_ERR;
              res_err  = ERR_BAD_TYPE;
              mode_nxt = MODE_HALT;
            end else begin
              res_fire = 1'b1;
              res_kind = EV_CLOSE;
              lvl_nxt  = lvl_m1;
              if (lvl_m1 != '0) begin
                top_nxt = below_done;
              end
            end
          end else if (is_digit) begin
            acc_nxt  = {{(ACC_W-4){1'b0}}, digit};
            key_nxt  = key_pos;
            mode_nxt = MODE_LEN;
          end else if ((in_byte != CH_I) && (in_byte != CH_L) && (in_byte != CH_D)) begin
            res_fire = 1'b1;
            res_kind = EV_ERR;
            res_err  = ERR_BAD_TYPE;
            mode_nxt = MODE_HALT;
          end else if (key_pos) begin
            res_fire = 1'b1;
            res_kind = EV_ERR;
            res_err  = ERR_KEY;
            mode_nxt = MODE_HALT;
          end else if (in_byte == CH_I) begin
            acc_nxt  = '0;
            seen_nxt = 1'b0;
            mode_nxt = MODE_INT;
          end else if (too_deep) begin
            res_fire = 1'b1;
            res_kind = EV_ERR;
            res_err  = ERR_DEEP;
            mode_nxt = MODE_HALT;
          end else begin
            // push: current top moves into the memory
            stk_wr_en        = (lvl_r != '0);
            top_nxt.dict     = (in_byte == CH_D);
            top_nxt.want_val = 1'b0;
            lvl_nxt          = lvl_r + LVL_W'(1);
            res_fire         = 1'b1;
            res_kind         = (in_byte == CH_D) ? EV_DICT : EV_LIST;
            res_lvl          = lvl_r + LVL_W'(1);
          end
        end
        MODE_LEN: begin
          if (is_digit) begin
            if (acc_stat.len_ovf) begin
              res_fire = 1'b1;
              res_kind = EV_ERR;
              res_err  = ERR_OVF;
              mode_nxt = MODE_HALT;
            end else begin
              acc_nxt = acc_sum;
            end
          end else if (in_byte != CH_COLON) begin
            res_fire = 1'b1;
            res_kind = EV_ERR;
            res_err  = ERR_BAD_LEN;
            mode_nxt = MODE_HALT;
          end else begin
            res_fire = 1'b1;
            res_kind = EV_HDR;
            res_last = (acc_r == '0);
            res_len  = acc_r[LENO_W-1:0];
            res_key  = key_r;
            left_nxt = acc_r[LEN_BITS-1:0];
            acc_nxt  = '0;
            if (acc_r == '0) begin
              mode_nxt = MODE_IDLE;
              top_nxt  = top_done;
            end else begin
              mode_nxt = MODE_BODY;
            end
          end
        end
        MODE_BODY: begin
          res_fire = 1'b1;
          res_kind = EV_BYTE;
          res_data = in_byte;
          res_last = (left_r == LEN_BITS'(1));
          res_key  = key_r;
          left_nxt = left_r - LEN_BITS'(1);
          if (left_r == LEN_BITS'(1)) begin
            mode_nxt = MODE_IDLE;
            top_nxt  = top_done;
          end
        end
        MODE_INT: begin
          if (in_byte == CH_E) begin
            if (!seen_r) begin
              res_fire = 1'b1;
              res_kind = EV_ERR;
              res_err  = ERR_EMPTY;
              mode_nxt = MODE_HALT;
            end else begin
              res_fire = 1'b1;
              res_kind = EV_INT;
              res_int  = acc_r;
              acc_nxt  = '0;
              seen_nxt = 1'b0;
              mode_nxt = MODE_IDLE;
              top_nxt  = top_done;
            end
          end else if (is_digit) begin
            if (acc_stat.int_ovf) begin
              res_fire = 1'b1;
              res_kind = EV_ERR;
              res_err  = ERR_OVF;
              mode_nxt = MODE_HALT;
            end else begin
              acc_nxt  = acc_sum;
              seen_nxt = 1'b1;
            end
          end else begin
            res_fire = 1'b1;
            res_kind = EV_ERR;
            res_err  = ERR_BAD_INT;
            mode_nxt = MODE_HALT;
          end
        end
        MODE_HALT: begin
          mode_nxt = MODE_HALT;
        end
        default: begin
          mode_nxt = MODE_HALT;
        end
      endcase
    end
  end

  // depth field keeps the low bits of the level count
  assign res_lvl_ext = {{NEST_W{1'b0}}, res_lvl};

  // parse state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      left_r      <= '0;
      lvl_r       <= '0;
      key_r       <= 1'b0;
      max_nest_r  <= MAX_NEST_RST;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
      left_r <= left_nxt;
      lvl_r  <= lvl_nxt;
      key_r  <= key_nxt;
      if (cfg_wr_en) begin
        max_nest_r <= cfg_wr_data;
      end
      if (in_acc && res_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (in_acc && res_fire) begin
      kind_r   <= res_kind;
      data_r   <= res_data;
      last_r   <= res_last;
      len_r    <= res_len;
      int_r    <= res_int;
      depth_r  <= res_lvl_ext[NEST_W-1:0];
      is_key_r <= res_key;
      err_r    <= (res_kind == EV_ERR) ? res_err : ERR_BAD_LEN;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_data_byte  = data_r;
  assign out_str_last   = last_r;
  assign out_str_length = len_r;
  assign out_int_value  = int_r;
  assign out_nest_depth = depth_r;
  assign out_is_key     = is_key_r;
  assign out_error_code = err_r;

`ifndef NO_ASSERTIONS
  // once halted, stays halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HALT |=> mode_r == MODE_HALT)
    else $error("tokenizer left halt without reset");

  // an error event always halts the parser
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_fire && res_kind == EV_ERR) |=> mode_r == MODE_HALT)
    else $error("error event without halt");

  // nesting never exceeds the stack
  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LVL_W'(STACK_DEPTH))
    else $error("nesting level beyond stack depth");

  // a string body always has bytes left
  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_BODY |-> left_r != '0)
    else $error("string body with no bytes left");

  // no result is produced while halted
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HALT |-> !res_fire)
    else $error("result produced while halted");
`endif

endmodule

// File: rtl/core/bst_stack_mem.sv
`timescale 1ns / 1ps
// bst_stack_mem: nesting-level memory, one write and one registered read
// port with same-cycle write forwarding; depends on bst_pkg
module bst_stack_mem #(
  parameter int unsigned STACK_DEPTH = bst_pkg::STACK_DEPTH_DEF,
  parameter int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  bst_pkg::lvl_ent_t wr_data,
  input  logic [AW-1:0]     rd_addr,
  output bst_pkg::lvl_ent_t rd_data
);
  import bst_pkg::*;

  lvl_ent_t mem [STACK_DEPTH];
  lvl_ent_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, a write to the same entry is passed straight through
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/bst_digit_acc.sv
`timescale 1ns / 1ps
// bst_digit_acc: decimal accumulate step acc*10+digit with length and
// integer overflow flags; depends on bst_pkg
module bst_digit_acc #(
  parameter int unsigned LEN_BITS = bst_pkg::LEN_BITS_DEF
) (
  input  logic [bst_pkg::ACC_W-1:0] acc,
  input  logic [3:0]                digit,
  output logic [bst_pkg::ACC_W-1:0] sum,
  output bst_pkg::acc_stat_t        stat
);
  import bst_pkg::*;

  logic [SUM_W-1:0] sum_full;

  // times ten as two shifted adds, then the digit
  assign sum_full = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(SUM_W-4){1'b0}}, digit};
  assign sum      = sum_full[ACC_W-1:0];

  // anything above the allowed width is overflow
  assign stat.len_ovf = |sum_full[SUM_W-1:LEN_BITS];
  assign stat.int_ovf = |sum_full[SUM_W-1:ACC_W];

endmodule
